// ----- src/lspx_pkg.sv -----
// shared types and constants for the looped sample player voice
package lspx_pkg;

	localparam int CFG_W      = 24;
	localparam int IDX_W      = 3;
	localparam int ADDR_W     = 16;
	localparam int PHASE_W    = 48;
	localparam int FADE_W     = 13;
	localparam int MAX_STEPS  = 17;
	localparam int STEP_CNT_W = 5;

	// config reset values
	localparam logic [15:0] AMP_RESET  = 16'd4096;
	localparam logic [19:0] RATE_RESET = 20'd65536;
	localparam logic [12:0] FADE_RESET = 13'd64;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_START = 2'd1,
		CMD_TICK  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		REG_AMPLITUDE   = 3'd0,
		REG_RATE_STEP   = 3'd1,
		REG_START_POS   = 3'd2,
		REG_LOOP_START  = 3'd3,
		REG_LOOP_END    = 3'd4,
		REG_DECAY_POINT = 3'd5,
		REG_FADE_LENGTH = 3'd6,
		REG_NOTE_LENGTH = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		RG_DECAY_XFADE = 3'd0,
		RG_DECAY_FADE  = 3'd1,
		RG_DECAY       = 3'd2,
		RG_FADE_IN     = 3'd3,
		RG_LOOP        = 3'd4
	} region_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic start;
		logic prep;
		logic dec1;
		logic dec2;
		logic rd_x;
		logic rd_y;
		logic mul1;
		logic mul2;
		logic dinit;
		logic div_step;
		logic fin;
		logic out1;
		logic out2;
		logic out3;
		logic out4;
	} ctl_t;

	// datapath to controller status
	typedef struct packed {
		logic more_steps;
		logic out_free;
	} sts_t;

endpackage

// ----- src/looped_sample_player_crossfade_top.sv -----
// top level of the looped sample player voice with crossfades
//
//  channel  signals                                   direction
//  in       in_valid in_ready command address sample_value   into block
//  out      out_valid out_ready audio_out             out of block
//  cfg      cfg_wr_en cfg_index cfg_data              into block
//
// load and start commands leave the controller idle and ready for the next
// command; a tick runs n source steps (n up to 17), each paced by the fade
// divider that yields one quotient bit per cycle and by the single read port
// of the sample store. arst_n clears control and playback state; the sample
// store is not cleared. A finished sample waits in the output register; a
// further tick stalls in state OUT3, before the output write, until it is taken.
module looped_sample_player_crossfade_top #(
	parameter int STORE_DEPTH = 65536,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [lspx_pkg::IDX_W-1:0]  cfg_index,
	input  logic [lspx_pkg::CFG_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  command,
	input  logic [lspx_pkg::ADDR_W-1:0] address,
	input  logic signed [15:0]          sample_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [15:0]          audio_out
);
	import lspx_pkg::*;

	ctl_t ctl;
	sts_t sts;

	lspx_ctrl #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.in_ready (in_ready),
		.ctl      (ctl),
		.sts      (sts)
	);

	lspx_dp #(
		.STORE_DEPTH (STORE_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.address      (address),
		.sample_value (sample_value),
		.ctl          (ctl),
		.sts          (sts),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.audio_out    (audio_out)
	);

endmodule

// ----- src/lspx_ram.sv -----
// generic single write port ram with registered read
module lspx_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/lspx_ctrl.sv -----
// sequencing state machine for the sampler voice
module lspx_ctrl #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [1:0]    command,
	output logic          in_ready,
	output lspx_pkg::ctl_t ctl,
	input  lspx_pkg::sts_t sts
);
	import lspx_pkg::*;

	localparam int QB  = SAMPLE_BITS + 1;
	localparam int DCW = $clog2(QB);

	typedef enum logic [15:0] {
		ST_IDLE  = 16'b0000000000000001,
		ST_PREP  = 16'b0000000000000010,
		ST_CHK   = 16'b0000000000000100,
		ST_DEC1  = 16'b0000000000001000,
		ST_DEC2  = 16'b0000000000010000,
		ST_RDX   = 16'b0000000000100000,
		ST_RDY   = 16'b0000000001000000,
		ST_MUL1  = 16'b0000000010000000,
		ST_MUL2  = 16'b0000000100000000,
		ST_DINIT = 16'b0000001000000000,
		ST_DIV   = 16'b0000010000000000,
		ST_FIN   = 16'b0000100000000000,
		ST_OUT1  = 16'b0001000000000000,
		ST_OUT2  = 16'b0010000000000000,
		ST_OUT3  = 16'b0100000000000000,
		ST_OUT4  = 16'b1000000000000000
	} state_t;

	state_t                state_q, state_n;
	logic [STEP_CNT_W-1:0] step_cnt_q;
	logic [DCW-1:0]        div_cnt_q;
	logic                  in_xfer;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer && command == CMD_TICK) begin
					state_n = ST_PREP;
				end
			end
			ST_PREP:  state_n = ST_CHK;
			ST_CHK: begin
				if (sts.more_steps && step_cnt_q != STEP_CNT_W'(MAX_STEPS)) begin
					state_n = ST_DEC1;
				end else begin
					state_n = ST_OUT1;
				end
			end
			ST_DEC1:  state_n = ST_DEC2;
			ST_DEC2:  state_n = ST_RDX;
			ST_RDX:   state_n = ST_RDY;
			ST_RDY:   state_n = ST_MUL1;
			ST_MUL1:  state_n = ST_MUL2;
			ST_MUL2:  state_n = ST_DINIT;
			ST_DINIT: state_n = ST_DIV;
			ST_DIV: begin
				if (div_cnt_q == DCW'(QB - 1)) begin
					state_n = ST_FIN;
				end
			end
			ST_FIN:   state_n = ST_CHK;
			ST_OUT1:  state_n = ST_OUT2;
			ST_OUT2:  state_n = ST_OUT3;
			ST_OUT3: begin
				if (sts.out_free) begin
					state_n = ST_OUT4;
				end
			end
			ST_OUT4:  state_n = ST_IDLE;
			default:  state_n = ST_IDLE;
		endcase
	end

	// state and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_cnt_q <= '0;
			div_cnt_q  <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == ST_PREP) begin
				step_cnt_q <= '0;
			end else if (state_q == ST_FIN) begin
				step_cnt_q <= step_cnt_q + 1'b1;
			end
			if (state_q == ST_DIV) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end else begin
				div_cnt_q <= '0;
			end
		end
	end

	// command decode
	always_comb begin
		ctl          = '0;
		ctl.load     = in_xfer && command == CMD_LOAD;
		ctl.start    = in_xfer && command == CMD_START;
		ctl.prep     = (state_q == ST_PREP);
		ctl.dec1     = (state_q == ST_DEC1);
		ctl.dec2     = (state_q == ST_DEC2);
		ctl.rd_x     = (state_q == ST_RDX);
		ctl.rd_y     = (state_q == ST_RDY);
		ctl.mul1     = (state_q == ST_MUL1);
		ctl.mul2     = (state_q == ST_MUL2);
		ctl.dinit    = (state_q == ST_DINIT);
		ctl.div_step = (state_q == ST_DIV);
		ctl.fin      = (state_q == ST_FIN);
		ctl.out1     = (state_q == ST_OUT1);
		ctl.out2     = (state_q == ST_OUT2);
		ctl.out3     = (state_q == ST_OUT3);
		ctl.out4     = (state_q == ST_OUT4);
	end

endmodule

// ----- src/lspx_dp.sv -----
// datapath: config, playback state, sample store, fade divider, output scaling
module lspx_dp #(
	parameter int STORE_DEPTH = 65536,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [lspx_pkg::IDX_W-1:0]    cfg_index,
	input  logic [lspx_pkg::CFG_W-1:0]    cfg_data,
	input  logic [lspx_pkg::ADDR_W-1:0]   address,
	input  logic signed [15:0]            sample_value,
	input  lspx_pkg::ctl_t                ctl,
	output lspx_pkg::sts_t                sts,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [15:0]            audio_out
);
	import lspx_pkg::*;

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int SW = SAMPLE_BITS;
	localparam int PW = SW + 15;
	localparam int QB = SW + 1;
	localparam int RW = 14;
	localparam int VW = SW + 18;
	localparam int XW = SW + 35;
	localparam int IW = 36;

	// config registers
	logic [15:0] amp_q, startp_q, lps_q, lpe_q, dcy_q;
	logic [19:0] rate_q;
	logic [12:0] fade_q;
	logic [23:0] nlen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q    <= AMP_RESET;
			rate_q   <= RATE_RESET;
			startp_q <= '0;
			lps_q    <= '0;
			lpe_q    <= '0;
			dcy_q    <= '0;
			fade_q   <= FADE_RESET;
			nlen_q   <= '0;
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_AMPLITUDE:   amp_q    <= cfg_data[15:0];
				REG_RATE_STEP:   rate_q   <= cfg_data[19:0];
				REG_START_POS:   startp_q <= cfg_data[15:0];
				REG_LOOP_START:  lps_q    <= cfg_data[15:0];
				REG_LOOP_END:    lpe_q    <= cfg_data[15:0];
				REG_DECAY_POINT: dcy_q    <= cfg_data[15:0];
				REG_FADE_LENGTH: fade_q   <= cfg_data[12:0];
				REG_NOTE_LENGTH: nlen_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// sample store
	logic [24:0]    addr_ext;
	logic [23:0]    samp_ext;
	logic           ram_we, ram_re;
	logic [AW-1:0]  ram_raddr;
	logic [SW-1:0]  ram_rdata;
	logic [AW-1:0]  x_addr_q, y_addr_q;
	logic           x_ok_q, y_ok_q;

	assign addr_ext = {9'd0, address};
	assign samp_ext = {{8{sample_value[15]}}, sample_value};
	assign ram_we   = ctl.load && (addr_ext < 25'(STORE_DEPTH));
	assign ram_re   = ctl.rd_x || ctl.rd_y;
	assign ram_raddr = ctl.rd_y ? y_addr_q : x_addr_q;

	lspx_ram #(
		.WIDTH (SW),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_ext[AW-1:0]),
		.wdata (samp_ext[SW-1:0]),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// playback state
	logic signed [31:0]    w_q;
	logic [31:0]           ii_q;
	logic signed [SW-1:0]  newest_q, older_q;
	logic [PHASE_W-1:0]    phase_q;

	// per tick derived loop points
	logic [12:0]        tau_n, tau_q;
	logic signed [17:0] ss_q, ds_q, dms_q;
	logic signed [26:0] d1_q, d2_q;
	logic [17:0]        ss_n, ds_n;
	logic [26:0]        d1_n, d2_n;

	assign tau_n = (fade_q == '0) ? 13'd1 : fade_q;
	assign ss_n  = {2'b00, lps_q} - {6'd0, tau_n[12:1]};
	assign ds_n  = {2'b00, lpe_q} - {6'd0, tau_n[12:1]};
	assign d1_n  = {3'd0, nlen_q} - ({11'd0, dcy_q} - {11'd0, lpe_q} + {15'd0, tau_n[12:1]});
	assign d2_n  = {3'd0, nlen_q} - {14'd0, tau_n} - 27'd1;

	always_ff @(posedge clk) begin
		if (ctl.prep) begin
			tau_q <= tau_n;
			ss_q  <= $signed(ss_n);
			ds_q  <= $signed(ds_n);
			dms_q <= $signed(ds_n - ss_n);
			d1_q  <= $signed(d1_n);
			d2_q  <= $signed(d2_n);
		end
	end

	// region decision
	logic signed [33:0] ii_s, k_n, e_n, d1x, d2x, dsx34;
	logic signed [31:0] ssx32, dsx32, wl_n;
	logic               in_decay, fade_in;
	region_t            rg_n, rg_q;
	logic signed [33:0] k_q, e_q;
	logic signed [31:0] wl_q;

	assign ii_s   = $signed({2'b00, ii_q});
	assign d1x    = 34'(d1_q);
	assign d2x    = 34'(d2_q);
	assign dsx34  = 34'(ds_q);
	assign ssx32  = 32'(ss_q);
	assign dsx32  = 32'(ds_q);
	assign k_n    = ii_s - d1x;
	assign e_n    = ii_s - d2x;
	assign in_decay = (ii_s >= d1x);
	assign fade_in  = (ii_q < {19'd0, tau_q});

	always_comb begin
		wl_n = w_q;
		if (in_decay) begin
			if (k_n < $signed({21'd0, tau_q})) begin
				rg_n = RG_DECAY_XFADE;
			end else if (ii_s > d2x) begin
				rg_n = RG_DECAY_FADE;
			end else begin
				rg_n = RG_DECAY;
			end
		end else if (fade_in) begin
			rg_n = RG_FADE_IN;
		end else begin
			rg_n = RG_LOOP;
			if (w_q == dsx32) begin
				wl_n = ssx32;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.dec1) begin
			rg_q <= rg_n;
			k_q  <= k_n;
			e_q  <= e_n;
			wl_q <= wl_n;
		end
	end

	// read indexes and fade coefficients
	logic signed [IW-1:0] di, wl36, lx, x_idx, y_idx;
	logic signed [32:0]   m;
	logic                 loopx;
	logic [12:0]          wt, ca_n, cb_n, ca_q, cb_q;
	logic signed [31:0]   wn_n, wn_q;

	assign di   = IW'(k_q) + IW'(ds_q);
	assign wl36 = IW'(wl_q);
	assign lx   = wl36 + IW'(dms_q);
	assign m    = 33'(wl_q) - 33'(ss_q);
	assign loopx = !m[32] && (ii_s >= dsx34) && (m < $signed({20'd0, tau_q}));
	assign wt   = (e_q >= $signed({21'd0, tau_q})) ? 13'd0 : tau_q - e_q[12:0];

	always_comb begin
		x_idx = wl36;
		y_idx = di;
		ca_n  = tau_q;
		cb_n  = '0;
		wn_n  = wl_q + 32'sd1;
		case (rg_q)
			RG_DECAY_XFADE: begin
				ca_n = tau_q - k_q[12:0];
				cb_n = k_q[12:0];
			end
			RG_DECAY_FADE: begin
				x_idx = di;
				ca_n  = wt;
				wn_n  = wl_q;
			end
			RG_DECAY: begin
				x_idx = di;
				wn_n  = wl_q;
			end
			RG_FADE_IN: begin
				ca_n = ii_q[12:0];
			end
			RG_LOOP: begin
				if (loopx) begin
					x_idx = lx;
					y_idx = wl36;
					ca_n  = tau_q - m[12:0];
					cb_n  = m[12:0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.dec2) begin
			x_addr_q <= x_idx[AW-1:0];
			y_addr_q <= y_idx[AW-1:0];
			x_ok_q   <= !x_idx[IW-1] && (x_idx[IW-2:0] < (IW-1)'(STORE_DEPTH));
			y_ok_q   <= !y_idx[IW-1] && (y_idx[IW-2:0] < (IW-1)'(STORE_DEPTH)) &&
			            (cb_n != '0);
			ca_q     <= ca_n;
			cb_q     <= cb_n;
			wn_q     <= wn_n;
		end
	end

	// weighted sum of the two reads
	logic signed [SW-1:0] x_q, y_q;
	logic signed [13:0]   ca_s, cb_s;
	logic signed [PW-1:0] pa, pb, acc_q;

	assign ca_s = $signed({1'b0, ca_q});
	assign cb_s = $signed({1'b0, cb_q});
	assign pa   = ca_s * x_q;
	assign pb   = cb_s * y_q;

	always_ff @(posedge clk) begin
		if (ctl.rd_y) begin
			x_q <= x_ok_q ? ram_rdata : '0;
		end
		if (ctl.mul1) begin
			y_q   <= y_ok_q ? ram_rdata : '0;
			acc_q <= pa;
		end else if (ctl.mul2) begin
			acc_q <= acc_q + pb;
		end
	end

	// restoring divide by fade length, one quotient bit per cycle
	logic [PW-1:0] mag;
	logic [RW:0]   trial;
	logic          ge;
	logic [RW-1:0] rem_q;
	logic [QB-1:0] quo_q;
	logic          neg_q;
	logic signed [QB:0] q_s, o_n;

	assign mag   = acc_q[PW-1] ? PW'(-acc_q) : acc_q;
	assign trial = {rem_q, quo_q[QB-1]};
	assign ge    = (trial >= {2'b00, tau_q});
	assign q_s   = $signed({1'b0, quo_q});
	assign o_n   = neg_q ? -q_s : q_s;

	always_ff @(posedge clk) begin
		if (ctl.dinit) begin
			neg_q <= acc_q[PW-1];
			rem_q <= mag[PW-1:QB];
			quo_q <= mag[QB-1:0];
		end else if (ctl.div_step) begin
			rem_q <= ge ? RW'(trial - {2'b00, tau_q}) : trial[RW-1:0];
			quo_q <= {quo_q[QB-2:0], ge};
		end
	end

	// playback state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q      <= '0;
			ii_q     <= '0;
			newest_q <= '0;
			older_q  <= '0;
			phase_q  <= '0;
		end else if (ctl.start) begin
			w_q      <= $signed({16'd0, startp_q});
			ii_q     <= '0;
			newest_q <= '0;
			older_q  <= '0;
			phase_q  <= '0;
		end else if (ctl.fin) begin
			older_q  <= newest_q;
			newest_q <= o_n[SW-1:0];
			w_q      <= wn_q;
			ii_q     <= ii_q + 32'd1;
		end else if (ctl.out4) begin
			phase_q  <= phase_q + PHASE_W'(rate_q);
		end
	end

	assign sts.more_steps = (phase_q[PHASE_W-1:16] >= ii_q);

	// interpolate, scale, round and saturate
	logic signed [SW:0]    diff;
	logic signed [VW-1:0]  v_n, v_s1;
	logic signed [16:0]    frac_s, amp_s;
	logic signed [SW+18:0] ph_s2;
	logic [31:0]           pl_s3;
	logic signed [XW-1:0]  xs, xr, rs;
	logic signed [15:0]    sat;

	assign diff   = (SW + 1)'(newest_q) - (SW + 1)'(older_q);
	assign frac_s = $signed({1'b0, phase_q[15:0]});
	assign amp_s  = $signed({1'b0, amp_q});
	assign v_n    = (VW'(older_q) <<< 16) + VW'(diff) * VW'(frac_s);
	assign xs     = (XW'(ph_s2) <<< 16) + $signed({{(XW - 32){1'b0}}, pl_s3});
	assign xr     = xs + $signed(XW'(1) <<< 27);
	assign rs     = xr >>> 28;

	always_comb begin
		if (rs > $signed(XW'(32767))) begin
			sat = 16'sh7fff;
		end else if (rs < -$signed(XW'(32768))) begin
			sat = 16'sh8000;
		end else begin
			sat = rs[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out1) begin
			v_s1 <= v_n;
		end
		if (ctl.out2) begin
			ph_s2 <= $signed(v_s1[VW-1:16]) * amp_s;
		end
		if (ctl.out3) begin
			pl_s3 <= v_s1[15:0] * amp_q;
		end
		if (ctl.out4) begin
			audio_out <= sat;
		end
	end

	// output holding register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out4) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for the looped sample player voice with crossfades
`timescale 1ns / 100ps

module tb;
	import lspx_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 30000;
	localparam int LONG_HOLD = 300;

	typedef struct {
		logic [1:0]         cmd;
		logic [15:0]        addr;
		logic signed [15:0] value;
	} voice_item_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [IDX_W-1:0]     cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [1:0]           command = CMD_LOAD;
	logic [ADDR_W-1:0]    address = '0;
	logic signed [15:0]   sample_value = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic signed [15:0]   audio_out;

	looped_sample_player_crossfade_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .address(address), .sample_value(sample_value),
		.out_valid(out_valid), .out_ready(out_ready), .audio_out(audio_out)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predicted voice state and registers
	logic signed [15:0] wave [0:65535];
	bit                 wave_set [0:65535];
	logic [15:0]        amp_q;
	logic [19:0]        rate_q;
	logic [15:0]        start_q, lstart_q, lend_q, decay_q;
	logic [12:0]        fade_q;
	logic [23:0]        note_q;
	logic [31:0]        play_pos, play_cnt;
	longint             newest, older;
	logic [47:0]        phase;
	bit                 read_miss;
	int                 miss_at;

	voice_item_t          pending_items [$];
	logic signed [15:0]   pending_audio [$];
	int   sent = 0, took = 0, got = 0, errors = 0, n_ticks = 0, n_loads = 0;
	int   n_phases = 0;
	bit   calm_in = 0, calm_out = 0;
	int   hold_asked = 0, hold_done = 0;

	function automatic longint wave_at(longint idx);
		if (idx < 0 || idx > 65535)
			return 0;
		if (!wave_set[idx]) begin
			if (!read_miss) miss_at = int'(idx);
			read_miss = 1;
			return 0;
		end
		return longint'(wave[idx]);
	endfunction

	function automatic longint blend(longint x, longint y, longint k, longint tau);
		return ((tau - k) * x + k * y) / tau;
	endfunction

	// one tick of the voice; on a read of an unloaded entry the state is restored
	task automatic predict_tick(output bit ok, output logic signed [15:0] res,
		output int need);
		logic [31:0] s_pos, s_cnt, whole;
		longint s_new, s_old, tau, h, ss, ds, d1, d2, ii, w, k, di, wt, o, v, x;
		longint frac;
		int steps;
		s_pos = play_pos; s_cnt = play_cnt; s_new = newest; s_old = older;
		tau = (fade_q == 0) ? 1 : longint'(fade_q);
		h = tau / 2;
		ss = longint'(lstart_q) - h;
		ds = longint'(lend_q) - h;
		d1 = longint'(note_q) - (longint'(decay_q) - longint'(lend_q) + h);
		d2 = longint'(note_q) - tau - 1;
		whole = phase[47:16];
		frac = longint'(phase[15:0]);
		steps = 0;
		read_miss = 0;
		while (whole >= play_cnt && steps < MAX_STEPS) begin
			ii = longint'(play_cnt);
			w = longint'($signed(play_pos));
			older = newest;
			if (ii >= d1) begin
				k = ii - d1;
				di = k + ds;
				if (k < tau) begin
					o = blend(wave_at(w), wave_at(di), k, tau);
					w++;
				end else if (ii > d2) begin
					wt = tau - (ii - d2);
					if (wt < 0) wt = 0;
					o = wave_at(di) * wt / tau;
				end else
					o = wave_at(di);
			end else if (ii < tau) begin
				o = wave_at(w) * ii / tau;
				w++;
			end else begin
				if (w == ds) w = ss;
				if (w >= ss && ii >= ds && w - ss < tau)
					o = blend(wave_at(w - ss + ds), wave_at(w), w - ss, tau);
				else
					o = wave_at(w);
				w++;
			end
			newest = o;
			play_pos = w[31:0];
			play_cnt = play_cnt + 1;
			steps++;
		end
		ok = !read_miss;
		need = miss_at;
		res = '0;
		if (!ok) begin
			play_pos = s_pos; play_cnt = s_cnt; newest = s_new; older = s_old;
			return;
		end
		v = older * 65536 + (newest - older) * frac;
		x = (v * longint'(amp_q) + 134217728) >>> 28;
		if (x > 32767) x = 32767;
		if (x < -32768) x = -32768;
		res = x[15:0];
		phase = phase + 48'(rate_q);
	endtask

	task automatic push_load(int addr, int value);
		voice_item_t it;
		it.cmd = CMD_LOAD; it.addr = addr[15:0]; it.value = value[15:0];
		wave[it.addr] = it.value;
		wave_set[it.addr] = 1;
		pending_items.push_back(it);
		n_loads++;
	endtask

	task automatic push_start();
		voice_item_t it;
		it.cmd = CMD_START; it.addr = 16'($urandom); it.value = 16'($urandom);
		play_pos = 32'(start_q); play_cnt = '0; newest = 0; older = 0; phase = '0;
		pending_items.push_back(it);
	endtask

	task automatic push_idle_cmd();
		voice_item_t it;
		it.cmd = CMD_UNUSED; it.addr = 16'($urandom); it.value = 16'($urandom);
		pending_items.push_back(it);
	endtask

	// loads any entry the tick would read before it is written, then queues the tick
	task automatic push_tick();
		voice_item_t it;
		bit ok;
		logic signed [15:0] res;
		int need;
		forever begin
			predict_tick(ok, res, need);
			if (ok) break;
			push_load(need, $urandom);
		end
		it.cmd = CMD_TICK; it.addr = 16'($urandom); it.value = 16'($urandom);
		pending_items.push_back(it);
		pending_audio.push_back(res);
		n_ticks++;
	endtask

	task automatic put_reg(reg_idx_t idx, int value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_W-1:0];
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_AMPLITUDE:   amp_q = value[15:0];
			REG_RATE_STEP:   rate_q = value[19:0];
			REG_START_POS:   start_q = value[15:0];
			REG_LOOP_START:  lstart_q = value[15:0];
			REG_LOOP_END:    lend_q = value[15:0];
			REG_DECAY_POINT: decay_q = value[15:0];
			REG_FADE_LENGTH: fade_q = value[12:0];
			REG_NOTE_LENGTH: note_q = value[23:0];
			default: ;
		endcase
	endtask

	// wait until every transfer is through and every result has come back
	task automatic drain();
		wait (pending_items.size() == 0 && took == sent && pending_audio.size() == 0);
		repeat (40) @(posedge clk);
	endtask

	function automatic int pause_len(bit calm);
		return calm ? 0 : $urandom_range(0, 12);
	endfunction

	// input driver
	int in_gap = 0;
	always @(negedge clk) begin
		voice_item_t it;
		if (!arst_n)
			in_valid <= 1'b0;
		else if (in_valid && took != sent)
			;
		else if (in_gap > 0) begin
			in_valid <= 1'b0;
			in_gap--;
		end else if (pending_items.size() > 0) begin
			it = pending_items.pop_front();
			in_valid <= 1'b1;
			command <= it.cmd;
			address <= it.addr;
			sample_value <= it.value;
			sent++;
			in_gap = pause_len(calm_in);
		end else
			in_valid <= 1'b0;
	end

	// result receiver with random stalls and one long holdoff
	int out_stall = 0, hold_left = 0, seen_got = 0;
	always @(negedge clk) begin
		if (got != seen_got) begin
			seen_got = got;
			out_stall = pause_len(calm_out);
		end
		if (hold_asked != hold_done) begin
			hold_done = hold_asked;
			hold_left = LONG_HOLD;
		end
		if (!arst_n)
			out_ready <= 1'b0;
		else if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (out_stall > 0) begin
			out_ready <= 1'b0;
			out_stall--;
		end else
			out_ready <= 1'b1;
	end

	// monitor: count transfers, check results, watchdog
	int idle_cycles = 0;
	always @(posedge clk) begin
		logic signed [15:0] want;
		if (arst_n) begin
			idle_cycles++;
			if (in_valid && in_ready) begin
				took++;
				idle_cycles = 0;
			end
			if (out_valid && out_ready) begin
				got++;
				idle_cycles = 0;
				if (pending_audio.size() == 0) begin
					$display("%0t: unexpected audio_out %0d", $time, audio_out);
					errors++;
				end else begin
					want = pending_audio.pop_front();
					if (audio_out !== want) begin
						$display("%0t: audio_out expected %0d actual %0d", $time, want,
							audio_out);
						errors++;
					end
				end
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, idle_cycles);
				$display("** looped_sample_player_crossfade_top: FAILED **");
				$finish;
			end
		end
	end

	// note settings for one phase; the first few hit the register extremes
	task automatic set_phase(int p);
		int ls, le;
		ls = $urandom_range(0, 300);
		le = ls + $urandom_range(20, 200);
		case (p)
			0: begin
				put_reg(REG_AMPLITUDE, 65535); put_reg(REG_RATE_STEP, 20'hFFFFF);
				put_reg(REG_START_POS, 0); put_reg(REG_LOOP_START, 0);
				put_reg(REG_LOOP_END, 0); put_reg(REG_DECAY_POINT, 0);
				put_reg(REG_FADE_LENGTH, 1); put_reg(REG_NOTE_LENGTH, 24'hFFFFFF);
			end
			1: begin
				put_reg(REG_AMPLITUDE, 0); put_reg(REG_RATE_STEP, 0);
				put_reg(REG_START_POS, 65535); put_reg(REG_LOOP_START, 65535);
				put_reg(REG_LOOP_END, 65535); put_reg(REG_DECAY_POINT, 65535);
				put_reg(REG_FADE_LENGTH, 4096); put_reg(REG_NOTE_LENGTH, 0);
			end
			2: begin
				put_reg(REG_AMPLITUDE, 4096); put_reg(REG_RATE_STEP, 3 * 65536 + 12345);
				put_reg(REG_START_POS, 10); put_reg(REG_LOOP_START, ls);
				put_reg(REG_LOOP_END, le); put_reg(REG_DECAY_POINT, le + 40);
				// zero fade length acts as one
				put_reg(REG_FADE_LENGTH, 0); put_reg(REG_NOTE_LENGTH, 200);
			end
			default: begin
				put_reg(REG_AMPLITUDE, $urandom_range(0, 65535));
				put_reg(REG_RATE_STEP, $urandom_range(1, 4 * 65536));
				put_reg(REG_START_POS, $urandom_range(0, 300));
				put_reg(REG_LOOP_START, ls);
				put_reg(REG_LOOP_END, le);
				put_reg(REG_DECAY_POINT, le + $urandom_range(0, 200));
				put_reg(REG_FADE_LENGTH, $urandom_range(1, 64));
				put_reg(REG_NOTE_LENGTH, $urandom_range(50, 1500));
			end
		endcase
		n_phases++;
	endtask

	initial begin
		int r;
		amp_q = AMP_RESET; rate_q = RATE_RESET; fade_q = FADE_RESET;
		start_q = '0; lstart_q = '0; lend_q = '0; decay_q = '0; note_q = '0;
		play_pos = '0; play_cnt = '0; newest = 0; older = 0; phase = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, every command, tick before any start
		push_load(0, -32768);
		push_load(65535, 32767);
		push_load(16'h5555, 16'h5555);
		push_load(16'hAAAA, -21846);
		push_idle_cmd();
		push_tick();
		push_tick();
		push_start();
		repeat (12) push_tick();
		push_start();
		push_tick();
		drain();

		// random phases with different note settings
		for (int p = 0; p < 9; p++) begin
			set_phase(p);
			calm_in = ($urandom_range(0, 3) == 0);
			calm_out = ($urandom_range(0, 3) == 0);
			for (int a = 0; a < 16; a++)
				push_load($urandom_range(0, 400), $urandom);
			push_start();
			if (p == 4) hold_asked++;
			for (int n = 0; n < 22; n++) begin
				r = $urandom_range(0, 99);
				if (r < 80) push_tick();
				else if (r < 92) push_load($urandom_range(0, 511), $urandom);
				else if (r < 95) push_load($urandom, $urandom);
				else if (r < 98) push_start();
				else push_idle_cmd();
			end
			drain();
		end

		$display("covered %0d ticks and %0d loads over %0d register settings",
			n_ticks, n_loads, n_phases);
		$display("including one long output holdoff and full-drain pauses");
		if (errors == 0 && pending_audio.size() == 0)
			$display("** looped_sample_player_crossfade_top: PASSED **");
		else
			$display("** looped_sample_player_crossfade_top: FAILED **");
		$finish;
	end

endmodule

// ----- looped_sample_player_crossfade_top.f -----
src/lspx_pkg.sv
src/lspx_ram.sv
src/lspx_ctrl.sv
src/lspx_dp.sv
src/looped_sample_player_crossfade_top.sv
tb/tb.sv
